// ===== hdl/mef_pkg.sv =====
// ----------------------------------------------------------------------------
// mef_pkg: shared definitions for the motor encoder feedback tracker
// Default constants, field widths, register indexes, operation codes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package mef_pkg;

  // Default values of the top-level parameters.
  localparam int unsigned COUNTS_PER_TURN_DEF = 8192;
  localparam int unsigned WARMUP_FRAMES_DEF   = 10;
  localparam int unsigned ANGLE_FRAC_BITS_DEF = 8;

  // Fixed field widths.
  localparam int unsigned CNT_W       = 32;  // total and relative counts
  localparam int unsigned ANGLE_W     = 16;  // raw rotor angle
  localparam int unsigned STEP_W      = 18;  // full corrected step, sign included
  localparam int unsigned STEP_OUT_W  = 14;
  localparam int unsigned SHAFT_OUT_W = 17;
  localparam int unsigned WARM_W      = 4;
  localparam int unsigned GEAR_W      = 8;
  localparam int unsigned ZOD_W       = 10;
  localparam int unsigned MAX_GEAR    = 255;
  localparam int unsigned DEG_PER_TURN = 360;
  localparam int unsigned HALF_TURN_DEG = 180;

  // Port widths.
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 168;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 10;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GEAR_RATIO  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET = 1'b1;

  // Operation codes carried in tuser.
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OFF_RUN,
    ST_PREP,
    ST_LOAD,
    ST_MOD_RUN,
    ST_SHAFT_RUN,
    ST_DONE
  } state_e;

endpackage

// ===== hdl/mef_sdiv.sv =====
// ----------------------------------------------------------------------------
// mef_sdiv: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle.
// The quotient shifts in where the numerator shifts out.
// ----------------------------------------------------------------------------
module mef_sdiv #(
  parameter int unsigned NUM_W = 38,
  parameter int unsigned DEN_W = 21
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quo_o,
  output logic [DEN_W-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [DEN_W:0]   part;
  logic             ge;

  always_comb begin
    part   = {rem_q, quo_q[NUM_W-1]};
    ge     = (part >= {1'b0, den_q});
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // The partial remainder stays below twice the divisor, so one trial
      // subtraction settles each bit.
      rem_d  = ge ? DEN_W'(part - {1'b0, den_q}) : part[DEN_W-1:0];
      quo_d  = {quo_q[NUM_W-2:0], ge};
      cnt_d  = cnt_q - CNT_W'(1);
      busy_d = (cnt_q != CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== hdl/motor_encoder_feedback_tracker.sv =====
// ----------------------------------------------------------------------------
// motor_encoder_feedback_tracker: multi-turn encoder feedback tracker
// A beat passes through the prep and load states, then two passes of the
// bit-serial divider on the shaft angle path; its result is loaded in ST_DONE.
// No new beat is taken until then, nor while the output is stalled; a zero
// offset write holds tready low from the write on until its division ends.
// Reset: counts, warm-up and offset cleared, gear ratio one; no clearing pass.
// ----------------------------------------------------------------------------
module motor_encoder_feedback_tracker
  import mef_pkg::*;
#(
  parameter int unsigned COUNTS_PER_TURN = COUNTS_PER_TURN_DEF,
  parameter int unsigned WARMUP_FRAMES   = WARMUP_FRAMES_DEF,
  parameter int unsigned ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Fields from bit 0 up: frame_byte_0 .. frame_byte_6, 8 bits each.
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0 up: operation.
  input  logic [0:0]             s_axis_tuser,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // Fields from bit 0 up: motor speed 16, motor current 16, temperature 8,
  // step_counts 14, total_counts 32, relative_counts 32, shaft_angle_q8 17,
  // relative_angle_q8 32, one zero pad bit.
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned CPT_W     = $clog2(COUNTS_PER_TURN + 1);
  localparam int unsigned SCALE     = DEG_PER_TURN * (2 ** ANGLE_FRAC_BITS);
  localparam int unsigned HALF_PER  = HALF_TURN_DEG * (2 ** ANGLE_FRAC_BITS);
  localparam int unsigned SCALE_W   = $clog2(SCALE + 1);
  localparam int unsigned DEN_W     = $clog2(COUNTS_PER_TURN * MAX_GEAR + 1);
  localparam int unsigned MOD_NUM_W = DEN_W + SCALE_W;
  localparam int unsigned OFF_NUM_W = ZOD_W + CPT_W;
  localparam int unsigned A_W0      = (MOD_NUM_W > CNT_W) ? MOD_NUM_W : CNT_W;
  localparam int unsigned A_W       = (OFF_NUM_W > A_W0) ? OFF_NUM_W : A_W0;
  localparam int unsigned REL_NUM_W = CNT_W + SCALE_W;

  localparam logic signed [STEP_W-1:0] CPT_S  = STEP_W'(COUNTS_PER_TURN);
  localparam logic signed [STEP_W-1:0] HALF_S = STEP_W'(COUNTS_PER_TURN / 2);
  localparam logic signed [SCALE_W:0]  SCALE_S = (SCALE_W + 1)'(SCALE);
  localparam logic signed [SCALE_W:0]  HALF_PER_S = (SCALE_W + 1)'(HALF_PER);
  localparam logic [REL_NUM_W-1:0] LIM_POS = REL_NUM_W'(64'h0000_0000_7FFF_FFFF);
  localparam logic [REL_NUM_W-1:0] LIM_NEG = REL_NUM_W'(64'h0000_0000_8000_0000);

  state_e state_q, state_d;

  // Tracking state.
  logic [ANGLE_W-1:0] prev_q, prev_d;
  logic [CNT_W-1:0]   acc_q, acc_d;
  logic [CNT_W-1:0]   rel_q, rel_d;
  logic [WARM_W-1:0]  warm_q, warm_d;
  logic [GEAR_W-1:0]  gear_q;
  logic [ZOD_W-1:0]   zod_q;
  logic [CNT_W-1:0]   off_q;

  // Per-beat holding registers and output register.
  logic [15:0]            hold_speed_q, hold_current_q;
  logic [7:0]             hold_temp_q;
  logic [STEP_OUT_W-1:0]  hold_step_q;
  logic [CNT_W-1:0]       total_q;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;
  logic                   m_valid_q;

  // Input decode.
  logic                      in_fire, op;
  logic [ANGLE_W-1:0]        cur_angle;
  logic signed [ANGLE_W-1:0] diff;
  logic signed [STEP_W-1:0]  step0, step1, step2;
  logic [15:0]               in_speed, in_current;
  logic [7:0]                in_temp;

  // Divider operands and results.
  logic                 start_a, start_b, busy_a, busy_b;
  logic [A_W-1:0]       a_num;
  logic [DEN_W-1:0]     a_den, den;
  logic [A_W-1:0]       quo_a;
  logic [DEN_W-1:0]     rem_a;
  logic [REL_NUM_W-1:0] b_num, quo_b;
  logic [GEAR_W-1:0]    gear_eff;
  logic [ZOD_W-1:0]     zin, zmag;
  logic [OFF_NUM_W-1:0] off_num;
  logic [MOD_NUM_W-1:0] m_scaled;
  logic [CNT_W-1:0]     tmag, rmag;
  logic                 cfg_off_wr, out_load, off_load;

  // Result shaping.
  logic [SCALE_W-1:0]      r_mag;
  logic signed [SCALE_W:0] sh0, sh1, sh2;
  logic signed [31:0]      sh_ext;
  logic [CNT_W-1:0]        rang;

  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign op         = s_axis_tuser[0];
  assign cfg_off_wr = cfg_we_i && (cfg_idx_i == CFG_ZERO_OFFSET);

  // Frame bytes are big-endian; byte 0 sits in the lowest tdata bits.
  assign cur_angle  = {s_axis_tdata[7:0], s_axis_tdata[15:8]};
  assign in_speed   = {s_axis_tdata[23:16], s_axis_tdata[31:24]};
  assign in_current = {s_axis_tdata[39:32], s_axis_tdata[47:40]};
  assign in_temp    = s_axis_tdata[55:48];

  always_comb begin
    diff  = signed'(cur_angle - prev_q);
    step0 = STEP_W'(diff);
    step1 = (step0 < -HALF_S) ? step0 + CPT_S : step0;
    step2 = (step1 > HALF_S) ? step1 - CPT_S : step1;
  end

  always_comb begin
    prev_d = prev_q;
    acc_d  = acc_q;
    rel_d  = rel_q;
    warm_d = warm_q;
    if (in_fire) begin
      if (op == OP_FRAME) begin
        prev_d = cur_angle;
        acc_d  = acc_q + CNT_W'(step2);
        if (warm_q < WARM_W'(WARMUP_FRAMES)) begin
          rel_d  = '0;
          warm_d = warm_q + WARM_W'(1);
        end else begin
          rel_d = rel_q + CNT_W'(step2);
        end
      end else begin
        rel_d = '0;
      end
    end
  end

  // Operand preparation.
  always_comb begin
    gear_eff = (gear_q == '0) ? GEAR_W'(1) : gear_q;
    den      = DEN_W'(gear_eff) * DEN_W'(COUNTS_PER_TURN);
    zin      = cfg_data_i[ZOD_W-1:0];
    zmag     = zin[ZOD_W-1] ? -zin : zin;
    off_num  = OFF_NUM_W'(zmag) * OFF_NUM_W'(COUNTS_PER_TURN);
    tmag     = total_q[CNT_W-1] ? -total_q : total_q;
    rmag     = rel_q[CNT_W-1] ? -rel_q : rel_q;
    b_num    = REL_NUM_W'(rmag) * REL_NUM_W'(SCALE);
    // The remainder of |total| by the divisor gives the angle within one
    // output turn, which avoids a separate modulo on the wide quotient.
    m_scaled = MOD_NUM_W'(rem_a) * MOD_NUM_W'(SCALE);
  end

  // Sequencer.
  always_comb begin
    state_d       = state_q;
    start_a       = 1'b0;
    start_b       = 1'b0;
    a_num         = '0;
    a_den         = den;
    out_load      = 1'b0;
    off_load      = 1'b0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = ST_PREP;
        end
      end
      ST_OFF_RUN: begin
        if (!busy_a) begin
          off_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_PREP: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        start_a = 1'b1;
        start_b = 1'b1;
        a_num   = A_W'(tmag);
        state_d = ST_MOD_RUN;
      end
      ST_MOD_RUN: begin
        if (!busy_a) begin
          start_a = 1'b1;
          a_num   = A_W'(m_scaled);
          state_d = ST_SHAFT_RUN;
        end
      end
      ST_SHAFT_RUN: begin
        if (!busy_a && !busy_b) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // A zero offset written while idle or converting is turned into counts before the next beat is taken.
    if (cfg_off_wr && (state_q == ST_IDLE || state_q == ST_OFF_RUN)) begin
      start_a       = 1'b1;
      a_num         = A_W'(off_num);
      a_den         = DEN_W'(DEG_PER_TURN);
      off_load      = 1'b0;
      s_axis_tready = 1'b0;
      state_d       = ST_OFF_RUN;
    end
  end

  mef_sdiv #(
    .NUM_W(A_W),
    .DEN_W(DEN_W)
  ) u_div_shaft (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_a),
    .num_i  (a_num),
    .den_i  (a_den),
    .busy_o (busy_a),
    .quo_o  (quo_a),
    .rem_o  (rem_a)
  );

  mef_sdiv #(
    .NUM_W(REL_NUM_W),
    .DEN_W(DEN_W)
  ) u_div_rel (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_b),
    .num_i  (b_num),
    .den_i  (den),
    .busy_o (busy_b),
    .quo_o  (quo_b),
    .rem_o  ()
  );

  // Result shaping: sign, wrap into half a turn either side, saturation.
  always_comb begin
    r_mag  = quo_a[SCALE_W-1:0];
    sh0    = total_q[CNT_W-1] ? -signed'({1'b0, r_mag}) : signed'({1'b0, r_mag});
    sh1    = (sh0 < 0) ? sh0 + SCALE_S : sh0;
    sh2    = (sh1 >= HALF_PER_S) ? sh1 - SCALE_S : sh1;
    sh_ext = 32'(sh2);
    if (rel_q[CNT_W-1]) begin
      rang = (quo_b > LIM_NEG) ? 32'h8000_0000 : -quo_b[CNT_W-1:0];
    end else begin
      rang = (quo_b > LIM_POS) ? 32'h7FFF_FFFF : quo_b[CNT_W-1:0];
    end
    m_data_d = {1'b0, rang, sh_ext[SHAFT_OUT_W-1:0], rel_q, total_q,
                hold_step_q, hold_temp_q, hold_current_q, hold_speed_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      prev_q    <= '0;
      acc_q     <= '0;
      rel_q     <= '0;
      warm_q    <= '0;
      gear_q    <= GEAR_W'(1);
      zod_q     <= '0;
      off_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      prev_q  <= prev_d;
      acc_q   <= acc_d;
      rel_q   <= rel_d;
      warm_q  <= warm_d;
      if (cfg_we_i && cfg_idx_i == CFG_GEAR_RATIO) begin
        gear_q <= cfg_data_i[GEAR_W-1:0];
      end
      if (cfg_off_wr) begin
        zod_q <= cfg_data_i[ZOD_W-1:0];
      end
      if (off_load) begin
        off_q <= zod_q[ZOD_W-1] ? -CNT_W'(quo_a) : CNT_W'(quo_a);
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (op == OP_FRAME) begin
        hold_speed_q   <= in_speed;
        hold_current_q <= in_current;
        hold_temp_q    <= in_temp;
        hold_step_q    <= step2[STEP_OUT_W-1:0];
      end else begin
        hold_speed_q   <= '0;
        hold_current_q <= '0;
        hold_temp_q    <= '0;
        hold_step_q    <= '0;
      end
    end
    if (state_q == ST_PREP) begin
      total_q <= acc_q - off_q;
    end
    if (out_load) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tdata  = m_data_q;
  assign m_axis_tvalid = m_valid_q;

endmodule
